// File: hdl/bfhs_pkg.sv
// Shared types and codes for the back/forward history stacks.
package bfhs_pkg;

  localparam int CMD_W = 2;
  localparam int STS_W = 2;

  localparam logic [CMD_W-1:0] CMD_VISIT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FWD   = 2'd2;

  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_NO_BACK = 2'd1;
  localparam logic [STS_W-1:0] STS_NO_FWD  = 2'd2;

  typedef struct packed {
    logic load;   // capture command and read both stack tops
    logic exec;   // apply the command and load the result register
  } bfhs_ctrl_t;

endpackage

// File: hdl/bfhs_in_if.sv
// Command channel: valid/ready with one history command per transfer.
interface bfhs_in_if #(
  parameter int TAG_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic [bfhs_pkg::CMD_W-1:0]  cmd;
  logic [TAG_BITS-1:0]         page_tag;

  modport source (output valid, output cmd, output page_tag, input ready);
  modport sink   (input valid, input cmd, input page_tag, output ready);
endinterface

// File: hdl/bfhs_out_if.sv
// Result channel: valid/ready with the history state after one command.
interface bfhs_out_if #(
  parameter int TAG_BITS = 32,
  parameter int CNT_W    = 7
);
  logic                        valid;
  logic                        ready;
  logic [TAG_BITS-1:0]         current_tag;
  logic                        current_present;
  logic [bfhs_pkg::STS_W-1:0]  status;
  logic [CNT_W-1:0]            back_depth;
  logic [CNT_W-1:0]            forward_depth;

  modport source (output valid, output current_tag, output current_present,
                  output status, output back_depth, output forward_depth,
                  input ready);
  modport sink   (input valid, input current_tag, input current_present,
                  input status, input back_depth, input forward_depth,
                  output ready);
endinterface

// File: hdl/bfhs_ctrl.sv
// Controller: sequences read and execute cycles and owns the result valid flag.
module bfhs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bfhs_pkg::bfhs_ctrl_t ctrl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    ctrl.load = in_valid && (state_r == S_IDLE);
    // hold in execute until the result register is free or being drained
    ctrl.exec = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (ctrl.load) state_nxt = S_EXEC;
      S_EXEC: if (ctrl.exec) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (ctrl.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/bfhs_dp.sv
// Datapath: both stack memories, counts, current entry and result register.
module bfhs_dp #(
  parameter int STACK_DEPTH = 64,
  parameter int TAG_BITS    = 32,
  parameter int CNT_W       = $clog2(STACK_DEPTH + 1),
  parameter int ADDR_W      = $clog2(STACK_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bfhs_pkg::bfhs_ctrl_t        ctrl,
  input  logic [bfhs_pkg::CMD_W-1:0]  in_cmd,
  input  logic [TAG_BITS-1:0]         in_page_tag,
  output logic [TAG_BITS-1:0]         out_current_tag,
  output logic                        out_current_present,
  output logic [bfhs_pkg::STS_W-1:0]  out_status,
  output logic [CNT_W-1:0]            out_back_depth,
  output logic [CNT_W-1:0]            out_forward_depth
);

  localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);

  logic [TAG_BITS-1:0] back_mem [STACK_DEPTH];
  logic [TAG_BITS-1:0] fwd_mem  [STACK_DEPTH];

  logic [bfhs_pkg::CMD_W-1:0] cmd_r;
  logic [TAG_BITS-1:0]        tag_r;
  logic [TAG_BITS-1:0]        back_rd_r, fwd_rd_r;

  logic [CNT_W-1:0]    back_cnt_r, back_cnt_nxt;
  logic [CNT_W-1:0]    fwd_cnt_r, fwd_cnt_nxt;
  logic [TAG_BITS-1:0] cur_r, cur_nxt;
  logic                cur_vld_r, cur_vld_nxt;
  logic [bfhs_pkg::STS_W-1:0] sts_nxt;

  logic [CNT_W-1:0] back_top, fwd_top;
  logic             back_push, fwd_push;

  assign back_top = back_cnt_r - CNT_W'(1);
  assign fwd_top  = fwd_cnt_r - CNT_W'(1);

  // Read both tops at transfer; only the one the command pops is used.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r     <= in_cmd;
      tag_r     <= in_page_tag;
      back_rd_r <= back_mem[back_top[ADDR_W-1:0]];
      fwd_rd_r  <= fwd_mem[fwd_top[ADDR_W-1:0]];
    end
  end

  always_comb begin
    back_cnt_nxt = back_cnt_r;
    fwd_cnt_nxt  = fwd_cnt_r;
    cur_nxt      = cur_r;
    cur_vld_nxt  = cur_vld_r;
    sts_nxt      = bfhs_pkg::STS_OK;
    back_push    = 1'b0;
    fwd_push     = 1'b0;
    unique case (cmd_r)
      bfhs_pkg::CMD_VISIT: begin
        back_push    = cur_vld_r && (back_cnt_r < FULL);
        back_cnt_nxt = back_push ? back_cnt_r + CNT_W'(1) : back_cnt_r;
        cur_nxt      = tag_r;
        cur_vld_nxt  = 1'b1;
        fwd_cnt_nxt  = '0;
      end
      bfhs_pkg::CMD_BACK: begin
        if (back_cnt_r == '0) begin
          sts_nxt = bfhs_pkg::STS_NO_BACK;
        end else begin
          fwd_push     = (fwd_cnt_r < FULL);
          fwd_cnt_nxt  = fwd_push ? fwd_cnt_r + CNT_W'(1) : fwd_cnt_r;
          back_cnt_nxt = back_top;
          cur_nxt      = back_rd_r;
          cur_vld_nxt  = 1'b1;
        end
      end
      bfhs_pkg::CMD_FWD: begin
        if (fwd_cnt_r == '0) begin
          sts_nxt = bfhs_pkg::STS_NO_FWD;
        end else begin
          back_push    = (back_cnt_r < FULL);
          back_cnt_nxt = back_push ? back_cnt_r + CNT_W'(1) : back_cnt_r;
          fwd_cnt_nxt  = fwd_top;
          cur_nxt      = fwd_rd_r;
          cur_vld_nxt  = 1'b1;
        end
      end
      default: ;  // unused code: leave everything as is
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && back_push) back_mem[back_cnt_r[ADDR_W-1:0]] <= cur_r;
    if (ctrl.exec && fwd_push)  fwd_mem[fwd_cnt_r[ADDR_W-1:0]]   <= cur_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      back_cnt_r <= '0;
      fwd_cnt_r  <= '0;
      cur_r      <= '0;
      cur_vld_r  <= 1'b0;
    end else if (ctrl.exec) begin
      back_cnt_r <= back_cnt_nxt;
      fwd_cnt_r  <= fwd_cnt_nxt;
      cur_r      <= cur_nxt;
      cur_vld_r  <= cur_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      out_current_tag     <= cur_vld_nxt ? cur_nxt : '0;
      out_current_present <= cur_vld_nxt;
      out_status          <= sts_nxt;
      out_back_depth      <= back_cnt_nxt;
      out_forward_depth   <= fwd_cnt_nxt;
    end
  end

endmodule

// File: hdl/back_forward_history_stacks.sv
// Top level: back/forward navigation history with two tag stacks.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    cmd, page_tag
//   out_ch    out   valid/ready    current_tag, current_present, status,
//                                  back_depth, forward_depth
//
// Each command first reads both stack tops from the stack memories
// (registered read), then pops/pushes and loads the result register.
// A new command is taken while the previous result still waits in the result
// register; execute holds while that register is full and not drained.
// Reset (rst_n low, synchronous) empties both stacks and clears the current
// entry; stack memories need no clearing pass.
module back_forward_history_stacks #(
  parameter int STACK_DEPTH = 64,
  parameter int TAG_BITS    = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  bfhs_in_if.sink      in_ch,
  bfhs_out_if.source   out_ch
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  bfhs_pkg::bfhs_ctrl_t ctrl;

  bfhs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctrl      (ctrl)
  );

  bfhs_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .CNT_W       (CNT_W)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctrl                (ctrl),
    .in_cmd              (in_ch.cmd),
    .in_page_tag         (in_ch.page_tag),
    .out_current_tag     (out_ch.current_tag),
    .out_current_present (out_ch.current_present),
    .out_status          (out_ch.status),
    .out_back_depth      (out_ch.back_depth),
    .out_forward_depth   (out_ch.forward_depth)
  );

  // one command in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("command taken while another is executing");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.back_depth <= CNT_W'(STACK_DEPTH)) &&
                     (out_ch.forward_depth <= CNT_W'(STACK_DEPTH)))
    else $error("stack depth beyond capacity");

  a_no_back_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == bfhs_pkg::STS_NO_BACK)
      |-> out_ch.back_depth == '0)
    else $error("back error reported with a non-empty back stack");

  a_empty_before_visit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.current_present)
      |-> (out_ch.back_depth == '0) && (out_ch.forward_depth == '0) &&
          (out_ch.current_tag == '0))
    else $error("stack contents without a current entry");

endmodule
